FILE: hw/rtl/owb_pkg.sv
// Shared types, codes and constants for the 1-Wire bus master.
// No dependencies; imported by every module of the block.
package owb_pkg;

    localparam int TIME_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W = 8;
    localparam int BIT_IDX_W = 3;

    // Request codes on the action field
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE0_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE1_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TAIL     = 3'd7;

    // Register defaults after reset
    localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [TIME_W-1:0] RST_RESET_RECOVER = 10'd500;
    localparam logic [TIME_W-1:0] RST_WRITE0_LOW    = 10'd70;
    localparam logic [TIME_W-1:0] RST_WRITE1_LOW    = 10'd10;
    localparam logic [TIME_W-1:0] RST_READ_LOW      = 10'd3;
    localparam logic [TIME_W-1:0] RST_READ_SAMPLE   = 10'd10;
    localparam logic [TIME_W-1:0] RST_SLOT_TAIL     = 10'd55;

    // Fixed phase lengths in ticks
    localparam logic [TIME_W-1:0] RESET_LEAD_TIME = 10'd20;
    localparam logic [TIME_W-1:0] SLOT_LEAD_TIME  = 10'd2;
    localparam logic [TIME_W-1:0] WRITE_ZERO_TAIL = 10'd2;

    // Phases within one slot or reset sequence
    localparam logic [1:0] PH_LEAD    = 2'd0;
    localparam logic [1:0] PH_LOW     = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;
    localparam logic [1:0] PH_TAIL    = 2'd3;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'b0001,
        OP_RESET = 4'b0010,
        OP_WRITE = 4'b0100,
        OP_READ  = 4'b1000
    } owb_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] reset_recovery_time;
        logic [TIME_W-1:0] write_zero_low_time;
        logic [TIME_W-1:0] write_one_low_time;
        logic [TIME_W-1:0] read_low_time;
        logic [TIME_W-1:0] read_sample_wait;
        logic [TIME_W-1:0] slot_tail_time;
    } owb_cfg_t;

    typedef struct packed {
        owb_op_t              op;
        logic [1:0]           phase;
        logic [TIME_W-1:0]    ticks_left;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic [BYTE_W-1:0]    shift;
        logic                 presence;
        logic                 drive_low;
        logic [BYTE_W-1:0]    read_hold;
    } owb_state_t;

    typedef struct packed {
        logic              line_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_byte;
        logic              rejected;
    } owb_result_t;

endpackage

FILE: hw/rtl/owb_cfg.sv
// Timing register file of the 1-Wire bus master.
// Depends on owb_pkg.
module owb_cfg
    import owb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output owb_cfg_t             cfg
);

    owb_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time      <= RST_RESET_LOW;
            cfg_reg.presence_wait_time  <= RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery_time <= RST_RESET_RECOVER;
            cfg_reg.write_zero_low_time <= RST_WRITE0_LOW;
            cfg_reg.write_one_low_time  <= RST_WRITE1_LOW;
            cfg_reg.read_low_time       <= RST_READ_LOW;
            cfg_reg.read_sample_wait    <= RST_READ_SAMPLE;
            cfg_reg.slot_tail_time      <= RST_SLOT_TAIL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:     cfg_reg.reset_low_time      <= cfg_data;
                CFG_PRESENCE_WAIT: cfg_reg.presence_wait_time  <= cfg_data;
                CFG_RESET_RECOVER: cfg_reg.reset_recovery_time <= cfg_data;
                CFG_WRITE0_LOW:    cfg_reg.write_zero_low_time <= cfg_data;
                CFG_WRITE1_LOW:    cfg_reg.write_one_low_time  <= cfg_data;
                CFG_READ_LOW:      cfg_reg.read_low_time       <= cfg_data;
                CFG_READ_SAMPLE:   cfg_reg.read_sample_wait    <= cfg_data;
                CFG_SLOT_TAIL:     cfg_reg.slot_tail_time      <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/owb_engine.sv
// Next-state and result logic for one request of the 1-Wire bus master.
// Purely combinational; depends on owb_pkg.
module owb_engine
    import owb_pkg::*;
(
    input  owb_cfg_t          cfg,
    input  owb_state_t        cur,
    input  logic [1:0]        action,
    input  logic [BYTE_W-1:0] write_byte,
    input  logic              line_level,
    output owb_state_t        nxt,
    output owb_result_t       res
);

    // Phase length (never zero) for an operation, phase and current data bit
    function automatic logic [TIME_W-1:0] phase_time(
        input owb_op_t    op,
        input logic [1:0] ph,
        input logic       bit_one,
        input owb_cfg_t   c
    );
        logic [TIME_W-1:0] t;
        t = {{(TIME_W-1){1'b0}}, 1'b1};
        unique case (op)
            OP_RESET:
            begin
                unique case (ph)
                    PH_LEAD:    t = RESET_LEAD_TIME;
                    PH_LOW:     t = c.reset_low_time;
                    PH_RELEASE: t = c.presence_wait_time;
                    default:    t = c.reset_recovery_time;
                endcase
            end
            OP_WRITE:
            begin
                unique case (ph)
                    PH_LEAD: t = SLOT_LEAD_TIME;
                    PH_LOW:  t = bit_one ? c.write_one_low_time : c.write_zero_low_time;
                    default: t = bit_one ? c.slot_tail_time : WRITE_ZERO_TAIL;
                endcase
            end
            OP_READ:
            begin
                unique case (ph)
                    PH_LEAD:    t = SLOT_LEAD_TIME;
                    PH_LOW:     t = c.read_low_time;
                    PH_RELEASE: t = c.read_sample_wait;
                    default:    t = c.slot_tail_time;
                endcase
            end
            default: ;
        endcase
        return (t == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : t;
    endfunction

    logic    enter;
    owb_op_t start_op;
    logic    is_tick;
    logic    last_phase;

    always_comb
    begin
        unique case (action)
            ACT_RESET: start_op = OP_RESET;
            ACT_WRITE: start_op = OP_WRITE;
            ACT_READ:  start_op = OP_READ;
            default:   start_op = OP_IDLE;
        endcase
    end

    assign is_tick    = (action == ACT_TICK);
    assign last_phase = (cur.op == OP_WRITE) ? (cur.phase == PH_RELEASE)
                                             : (cur.phase == PH_TAIL);

    always_comb
    begin
        nxt          = cur;
        enter        = 1'b0;
        res.line_low = 1'b0;
        res.done_res = 1'b0;
        res.rejected = 1'b0;

        if (!is_tick)
        begin
            res.line_low = cur.drive_low;
            if (cur.op != OP_IDLE)
            begin
                res.rejected = 1'b1;
            end
            else
            begin
                nxt.op      = start_op;
                nxt.bit_idx = '0;
                nxt.shift   = (action == ACT_WRITE) ? write_byte : '0;
                nxt.phase   = PH_LEAD;
                enter       = 1'b1;
            end
        end
        else if (cur.op != OP_IDLE)
        begin
            res.line_low = cur.drive_low;
            if (cur.ticks_left <= {{(TIME_W-1){1'b0}}, 1'b1})
            begin
                // End of phase: sample or shift at the end of the release phase
                if (cur.phase == PH_RELEASE)
                begin
                    unique case (cur.op)
                        OP_RESET: nxt.presence = ~line_level;
                        OP_READ:  nxt.shift = {line_level, cur.shift[BYTE_W-1:1]};
                        default:  nxt.shift = {1'b0, cur.shift[BYTE_W-1:1]};
                    endcase
                end
                if (!last_phase)
                begin
                    nxt.phase = cur.phase + 2'd1;
                    enter     = 1'b1;
                end
                else if (cur.op != OP_RESET && cur.bit_idx != LAST_BIT)
                begin
                    nxt.bit_idx = cur.bit_idx + 3'd1;
                    nxt.phase   = PH_LEAD;
                    enter       = 1'b1;
                end
                else
                begin
                    if (cur.op == OP_READ)
                    begin
                        nxt.read_hold = nxt.shift;
                    end
                    nxt.op         = OP_IDLE;
                    nxt.phase      = PH_LEAD;
                    nxt.ticks_left = '0;
                    nxt.bit_idx    = '0;
                    nxt.drive_low  = 1'b0;
                    res.done_res   = 1'b1;
                end
            end
            else
            begin
                nxt.ticks_left = cur.ticks_left - {{(TIME_W-1){1'b0}}, 1'b1};
            end
        end

        if (enter)
        begin
            nxt.ticks_left = phase_time(nxt.op, nxt.phase, nxt.shift[0], cfg);
            nxt.drive_low  = (nxt.phase == PH_LOW);
        end

        res.busy_res  = (nxt.op != OP_IDLE);
        res.presence  = nxt.presence;
        res.read_byte = nxt.read_hold;
    end

endmodule

FILE: hw/rtl/onewire_bus_master_top.sv
// Top level of the 1-Wire bus master: request and result registers, bus state.
// Depends on owb_pkg, owb_cfg and owb_engine.
//
// Each request is a tick (one microsecond of bus time, with the sampled line
// level) or a command that starts a reset with presence detect, a byte write
// or a byte read. Requests pass an input register, then the next-state logic
// updates the bus state and a result register holds the outcome, so one
// request is taken per cycle as long as the result side keeps up. A stalled
// result holds in its register while the request behind it waits in the input
// register; only then, with both registers full, is in_stall raised. All bus
// timing is counted in ticks against the eight timing registers, which may be
// rewritten through the configuration port only while the block is idle. A
// command sent while an operation is running is answered with rejected set
// and otherwise ignored. Bytes travel LSB first.
module onewire_bus_master_top
    import owb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [BYTE_W-1:0]    write_byte,
    input  logic                 line_level,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 line_low,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 presence,
    output logic [BYTE_W-1:0]    read_byte,
    output logic                 rejected,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    owb_cfg_t    cfg;

    // Input register
    logic              in_vld_reg;
    logic [1:0]        action_reg;
    logic [BYTE_W-1:0] write_byte_reg;
    logic              line_level_reg;

    // Bus state and result register
    owb_state_t  state_reg;
    owb_state_t  state_next;
    owb_result_t res_next;
    owb_result_t res_reg;
    logic        out_vld_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;

    assign cfg_ready = 1'b1;

    owb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owb_engine u_engine (
        .cfg        (cfg),
        .cur        (state_reg),
        .action     (action_reg),
        .write_byte (write_byte_reg),
        .line_level (line_level_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // Result register drains when empty or taken; request moves into it then.
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg     <= action;
            write_byte_reg <= write_byte;
            line_level_reg <= line_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Bus state moves only when a request is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op         <= OP_IDLE;
            state_reg.phase      <= PH_LEAD;
            state_reg.ticks_left <= '0;
            state_reg.bit_idx    <= '0;
            state_reg.shift      <= '0;
            state_reg.presence   <= 1'b0;
            state_reg.drive_low  <= 1'b0;
            state_reg.read_hold  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign line_low  = res_reg.line_low;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign presence  = res_reg.presence;
    assign read_byte = res_reg.read_byte;
    assign rejected  = res_reg.rejected;

endmodule
